// ----- sv/bcrc_pkg.sv -----
package bcrc_pkg;

	localparam int TEMP_W   = 10;
	localparam int LIGHT_W  = 10;
	localparam int DEG_W    = 9;
	localparam int LIMIT_W  = 6;
	localparam int THRESH_W = 9;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 9;

	// degrees = (sample * 125) >> 8
	localparam int DEG_MUL   = 125;
	localparam int DEG_SHIFT = 8;
	localparam int DEG_PROD_W = TEMP_W + 7;
	// light / 3 as (light * 683) >> 11, exact for 10-bit inputs
	localparam int DIV3_MUL   = 683;
	localparam int DIV3_SHIFT = 11;
	localparam int DIV3_PROD_W = LIGHT_W + 10;

	localparam logic [LIMIT_W-1:0]  TICK_LIMIT_RST     = LIMIT_W'(60);
	localparam logic [DEG_W-1:0]    ALARM_HIGH_RST     = DEG_W'(45);
	localparam logic [DEG_W-1:0]    ALARM_LOW_RST      = DEG_W'(5);
	localparam logic [DEG_W-1:0]    COOL_ABOVE_RST     = DEG_W'(28);
	localparam logic [DEG_W-1:0]    HEAT_BELOW_RST     = DEG_W'(18);
	localparam logic [THRESH_W-1:0] DARK_THRESHOLD_RST = THRESH_W'(150);

	typedef enum logic [1:0] {
		REQ_TICK   = 2'd0,
		REQ_NIGHT  = 2'd1,
		REQ_SAMPLE = 2'd2,
		REQ_POLL   = 2'd3
	} req_kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TICK_LIMIT     = 3'd0,
		CFG_ALARM_HIGH     = 3'd1,
		CFG_ALARM_LOW      = 3'd2,
		CFG_COOL_ABOVE     = 3'd3,
		CFG_HEAT_BELOW     = 3'd4,
		CFG_DARK_THRESHOLD = 3'd5
	} cfg_idx_t;

	typedef enum logic [2:0] {
		PH_IDLE        = 3'd0,
		PH_WATER_OPEN  = 3'd1,
		PH_WATER_CLOSE = 3'd2,
		PH_FOOD_OPEN   = 3'd3,
		PH_FOOD_CLOSE  = 3'd4
	} phase_t;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [TEMP_W-1:0]  temp_sample;
		logic [LIGHT_W-1:0] light_sample;
		logic               night_pin;
		logic               water_short;
		logic               food_short;
		logic               water_open_switch;
		logic               water_closed_switch;
		logic               food_open_switch;
		logic               food_closed_switch;
	} req_t;

	typedef struct packed {
		logic             water_open_drive;
		logic             water_close_drive;
		logic             food_open_drive;
		logic             food_close_drive;
		logic             cooling_on;
		logic             heating_on;
		logic             lights_on;
		logic             refill_busy;
		logic             alarm_on;
		logic [DEG_W-1:0] temperature_degrees;
		logic             daylight_high;
	} rsp_t;

endpackage

// ----- sv/barn_climate_and_refill_controller_unit.sv -----
// An accepted item's result is registered in the output buffer.
// Throughput: one item per cycle while req_stall is low; a two-entry output
// buffer (result register plus skid register) lets an item be taken while a
// result is still waiting. req_stall rises only when both entries are full.
// Reset (arst_n low, asynchronous): registers to their defaults, latches and
// counters cleared, refill sequencer idle, output buffer empty.
module barn_climate_and_refill_controller_unit
	import bcrc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  req_t                  req,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output rsp_t                  rsp,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// configuration
	logic [LIMIT_W-1:0]  tick_limit_q;
	logic [DEG_W-1:0]    alarm_high_q, alarm_low_q, cool_above_q, heat_below_q;
	logic [THRESH_W-1:0] dark_threshold_q;

	// controller state
	logic [LIMIT_W-1:0] tick_count_q, tick_count_d;
	logic night_mode_q, night_mode_d;
	logic alarm_q, alarm_d;
	logic cooling_q, cooling_d;
	logic heating_q, heating_d;
	logic lights_q, lights_d;
	logic food_pending_q, food_pending_d;
	logic night_pend_q, night_pend_d;
	logic [DEG_W-1:0] last_temp_q, last_temp_d;
	logic daylight_q, daylight_d;
	phase_t phase_q, phase_d;

	// output buffer
	rsp_t rsp_q, skid_q, rsp_new;
	logic rsp_valid_q, skid_valid_q;

	logic accept, pop, busy;
	logic [DEG_PROD_W-1:0]  deg_prod;
	logic [DIV3_PROD_W-1:0] light_prod;
	logic [DEG_W-1:0]       deg;
	logic [THRESH_W-1:0]    light_div3;
	logic [LIMIT_W-1:0]     tick_inc;
	logic                   dark;

	assign cfg_ready = 1'b1;
	assign req_stall = skid_valid_q;
	assign accept    = req_valid && !req_stall;
	assign pop       = rsp_valid_q && !rsp_stall;
	assign busy      = (phase_q != PH_IDLE);

	assign deg_prod   = DEG_PROD_W'(req.temp_sample) * DEG_PROD_W'(DEG_MUL);
	assign deg        = deg_prod[DEG_SHIFT +: DEG_W];
	assign light_prod = DIV3_PROD_W'(req.light_sample) * DIV3_PROD_W'(DIV3_MUL);
	assign light_div3 = light_prod[DIV3_SHIFT +: THRESH_W];
	assign dark       = {1'b0, light_div3} > ({1'b0, dark_threshold_q} + (THRESH_W+1)'(1));
	assign tick_inc   = tick_count_q + LIMIT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_limit_q     <= TICK_LIMIT_RST;
			alarm_high_q     <= ALARM_HIGH_RST;
			alarm_low_q      <= ALARM_LOW_RST;
			cool_above_q     <= COOL_ABOVE_RST;
			heat_below_q     <= HEAT_BELOW_RST;
			dark_threshold_q <= DARK_THRESHOLD_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_TICK_LIMIT:     tick_limit_q     <= cfg_data[LIMIT_W-1:0];
				CFG_ALARM_HIGH:     alarm_high_q     <= cfg_data[DEG_W-1:0];
				CFG_ALARM_LOW:      alarm_low_q      <= cfg_data[DEG_W-1:0];
				CFG_COOL_ABOVE:     cool_above_q     <= cfg_data[DEG_W-1:0];
				CFG_HEAT_BELOW:     heat_below_q     <= cfg_data[DEG_W-1:0];
				CFG_DARK_THRESHOLD: dark_threshold_q <= cfg_data[THRESH_W-1:0];
				default: ;
			endcase
		end
	end

	// next state for one item
	always_comb begin
		tick_count_d   = tick_count_q;
		night_mode_d   = night_mode_q;
		alarm_d        = alarm_q;
		cooling_d      = cooling_q;
		heating_d      = heating_q;
		lights_d       = lights_q;
		food_pending_d = food_pending_q;
		night_pend_d   = night_pend_q;
		last_temp_d    = last_temp_q;
		daylight_d     = daylight_q;
		phase_d        = phase_q;

		if (req.req_type == REQ_POLL) begin
			unique case (phase_q)
				PH_IDLE: ;
				PH_WATER_OPEN:
					if (!req.water_open_switch) phase_d = PH_WATER_CLOSE;
				PH_WATER_CLOSE:
					if (!req.water_closed_switch) begin
						if (food_pending_q) phase_d = PH_FOOD_OPEN;
						else phase_d = PH_IDLE;
					end
				PH_FOOD_OPEN:
					if (!req.food_open_switch) phase_d = PH_FOOD_CLOSE;
				PH_FOOD_CLOSE:
					if (!req.food_closed_switch) phase_d = PH_IDLE;
				default: phase_d = PH_IDLE;
			endcase
			// sequence end: apply a night edge held back while busy
			if (busy && phase_d == PH_IDLE) begin
				food_pending_d = 1'b0;
				if (night_pend_q) begin
					night_pend_d = 1'b0;
					lights_d     = 1'b0;
					night_mode_d = 1'b1;
				end
			end
		end else if (req.req_type == REQ_NIGHT) begin
			if (busy) begin
				night_pend_d = 1'b1;
			end else begin
				lights_d     = 1'b0;
				night_mode_d = 1'b1;
			end
		end else if (!busy) begin
			if (req.req_type == REQ_TICK) begin
				if (!night_mode_q) begin
					tick_count_d = tick_inc;
					if (tick_inc >= tick_limit_q) begin
						tick_count_d = '0;
						if (req.water_short) begin
							food_pending_d = req.food_short;
							phase_d        = PH_WATER_OPEN;
						end else if (req.food_short) begin
							food_pending_d = 1'b0;
							phase_d        = PH_FOOD_OPEN;
						end
					end
				end
			end else begin
				last_temp_d = deg;
				if (alarm_q && deg < alarm_high_q && deg > alarm_low_q) alarm_d = 1'b0;
				if (deg > alarm_high_q || deg < alarm_low_q) alarm_d = 1'b1;
				if (deg > cool_above_q) begin
					cooling_d = 1'b1;
				end else if (deg < heat_below_q) begin
					heating_d = 1'b1;
				end else begin
					cooling_d = 1'b0;
					heating_d = 1'b0;
				end
				daylight_d = !dark;
				lights_d   = dark && !night_mode_q;
				if (night_mode_q && req.night_pin) night_mode_d = 1'b0;
			end
		end
	end

	// result from the state after the item
	always_comb begin
		rsp_new.water_open_drive    = (phase_d == PH_WATER_OPEN);
		rsp_new.water_close_drive   = (phase_d == PH_WATER_CLOSE);
		rsp_new.food_open_drive     = (phase_d == PH_FOOD_OPEN);
		rsp_new.food_close_drive    = (phase_d == PH_FOOD_CLOSE);
		rsp_new.cooling_on          = cooling_d;
		rsp_new.heating_on          = heating_d;
		rsp_new.lights_on           = lights_d;
		rsp_new.refill_busy         = (phase_d != PH_IDLE);
		rsp_new.alarm_on            = alarm_d;
		rsp_new.temperature_degrees = last_temp_d;
		rsp_new.daylight_high       = daylight_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_count_q   <= '0;
			night_mode_q   <= 1'b0;
			alarm_q        <= 1'b0;
			cooling_q      <= 1'b0;
			heating_q      <= 1'b0;
			lights_q       <= 1'b0;
			food_pending_q <= 1'b0;
			night_pend_q   <= 1'b0;
			last_temp_q    <= '0;
			daylight_q     <= 1'b0;
			phase_q        <= PH_IDLE;
		end else if (accept) begin
			tick_count_q   <= tick_count_d;
			night_mode_q   <= night_mode_d;
			alarm_q        <= alarm_d;
			cooling_q      <= cooling_d;
			heating_q      <= heating_d;
			lights_q       <= lights_d;
			food_pending_q <= food_pending_d;
			night_pend_q   <= night_pend_d;
			last_temp_q    <= last_temp_d;
			daylight_q     <= daylight_d;
			phase_q        <= phase_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (accept) begin
			if (rsp_valid_q && !pop) begin
				skid_valid_q <= 1'b1;
			end else begin
				rsp_valid_q <= 1'b1;
			end
		end else if (pop) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) rsp_q <= skid_q;
		end else if (accept) begin
			if (rsp_valid_q && !pop) skid_q <= rsp_new;
			else rsp_q <= rsp_new;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ----- tb/sv/barn_result_checker.sv -----
`timescale 1ns / 1ps

module barn_result_checker
	import bcrc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	input  logic                  req_stall,
	input  req_t                  req,
	input  logic                  rsp_valid,
	input  logic                  rsp_stall,
	input  rsp_t                  rsp,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    mismatches,
	output int                    outstanding
);

	// register copies
	logic [LIMIT_W-1:0]  lim_ticks;
	logic [DEG_W-1:0]    hi_alarm;
	logic [DEG_W-1:0]    lo_alarm;
	logic [DEG_W-1:0]    cool_thr;
	logic [DEG_W-1:0]    heat_thr;
	logic [THRESH_W-1:0] dark_thr;

	// controller state
	logic [LIMIT_W-1:0] ticks_seen;
	logic               is_night;
	logic               alarm_q;
	logic               cool_q;
	logic               heat_q;
	logic               lamps_q;
	phase_t             phase;
	logic               food_next;
	logic               night_deferred;
	logic [DEG_W-1:0]   deg_q;
	logic               daylight_q;

	rsp_t expected_outputs[$];
	int   fail_count = 0;

	assign mismatches = fail_count;

	function automatic void restore_defaults();
		lim_ticks      = TICK_LIMIT_RST;
		hi_alarm       = ALARM_HIGH_RST;
		lo_alarm       = ALARM_LOW_RST;
		cool_thr       = COOL_ABOVE_RST;
		heat_thr       = HEAT_BELOW_RST;
		dark_thr       = DARK_THRESHOLD_RST;
		ticks_seen     = '0;
		is_night       = 1'b0;
		alarm_q        = 1'b0;
		cool_q         = 1'b0;
		heat_q         = 1'b0;
		lamps_q        = 1'b0;
		phase          = PH_IDLE;
		food_next      = 1'b0;
		night_deferred = 1'b0;
		deg_q          = '0;
		daylight_q     = 1'b0;
	endfunction

	// sequence over: a night edge seen while busy lands now
	function automatic void finish_refill();
		phase     = PH_IDLE;
		food_next = 1'b0;
		if (night_deferred) begin
			night_deferred = 1'b0;
			lamps_q        = 1'b0;
			is_night       = 1'b1;
		end
	endfunction

	function automatic rsp_t next_barn_outputs(req_t item);
		rsp_t               r;
		logic               busy;
		logic [DEG_W-1:0]   deg;
		logic [LIGHT_W-1:0] third;
		logic               dark;
		busy = (phase != PH_IDLE);
		case (req_kind_t'(item.req_type))
			REQ_POLL: begin
				case (phase)
					PH_IDLE: ;
					PH_WATER_OPEN: if (!item.water_open_switch) phase = PH_WATER_CLOSE;
					PH_WATER_CLOSE: begin
						if (!item.water_closed_switch) begin
							if (food_next) phase = PH_FOOD_OPEN;
							else finish_refill();
						end
					end
					PH_FOOD_OPEN: if (!item.food_open_switch) phase = PH_FOOD_CLOSE;
					PH_FOOD_CLOSE: if (!item.food_closed_switch) finish_refill();
					default: finish_refill();
				endcase
			end
			REQ_NIGHT: begin
				if (busy) begin
					night_deferred = 1'b1;
				end else begin
					lamps_q  = 1'b0;
					is_night = 1'b1;
				end
			end
			REQ_TICK: begin
				if (!busy && !is_night) begin
					ticks_seen = ticks_seen + 1'b1;
					if (ticks_seen >= lim_ticks) begin
						ticks_seen = '0;
						if (item.water_short) begin
							food_next = item.food_short;
							phase     = PH_WATER_OPEN;
						end else if (item.food_short) begin
							food_next = 1'b0;
							phase     = PH_FOOD_OPEN;
						end
					end
				end
			end
			default: begin
				if (!busy) begin
					deg   = DEG_W'((17'(item.temp_sample) * 17'd125) >> 8);
					deg_q = deg;
					if (alarm_q && deg < hi_alarm && deg > lo_alarm) alarm_q = 1'b0;
					if (deg > hi_alarm || deg < lo_alarm) alarm_q = 1'b1;
					if (deg > cool_thr) begin
						cool_q = 1'b1;
					end else if (deg < heat_thr) begin
						heat_q = 1'b1;
					end else begin
						cool_q = 1'b0;
						heat_q = 1'b0;
					end
					// light/3 - 1 > threshold, kept unsigned
					third      = item.light_sample / 10'd3;
					dark       = third > (10'(dark_thr) + 10'd1);
					daylight_q = !dark;
					lamps_q    = dark && !is_night;
					if (is_night && item.night_pin) is_night = 1'b0;
				end
			end
		endcase
		r.water_open_drive    = (phase == PH_WATER_OPEN);
		r.water_close_drive   = (phase == PH_WATER_CLOSE);
		r.food_open_drive     = (phase == PH_FOOD_OPEN);
		r.food_close_drive    = (phase == PH_FOOD_CLOSE);
		r.cooling_on          = cool_q;
		r.heating_on          = heat_q;
		r.lights_on           = lamps_q;
		r.refill_busy         = (phase != PH_IDLE);
		r.alarm_on            = alarm_q;
		r.temperature_degrees = deg_q;
		r.daylight_high       = daylight_q;
		return r;
	endfunction

	function automatic string show(rsp_t r);
		return $sformatf({"wo=%0b wc=%0b fo=%0b fc=%0b cool=%0b heat=%0b lights=%0b ",
			"busy=%0b alarm=%0b deg=%0d day=%0b"},
			r.water_open_drive, r.water_close_drive, r.food_open_drive,
			r.food_close_drive, r.cooling_on, r.heating_on, r.lights_on,
			r.refill_busy, r.alarm_on, r.temperature_degrees, r.daylight_high);
	endfunction

	function automatic void note_mismatch(string msg);
		fail_count++;
		if (fail_count <= 10) $display("%s", msg);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			restore_defaults();
			expected_outputs.delete();
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					CFG_TICK_LIMIT:     lim_ticks = cfg_data[LIMIT_W-1:0];
					CFG_ALARM_HIGH:     hi_alarm  = cfg_data[DEG_W-1:0];
					CFG_ALARM_LOW:      lo_alarm  = cfg_data[DEG_W-1:0];
					CFG_COOL_ABOVE:     cool_thr  = cfg_data[DEG_W-1:0];
					CFG_HEAT_BELOW:     heat_thr  = cfg_data[DEG_W-1:0];
					CFG_DARK_THRESHOLD: dark_thr  = cfg_data[THRESH_W-1:0];
					default: ;
				endcase
			end
			if (rsp_valid && !rsp_stall) begin
				if (expected_outputs.size() == 0) begin
					note_mismatch($sformatf("%0t: result with nothing expected: %s",
						$realtime, show(rsp)));
				end else begin
					want = expected_outputs.pop_front();
					if (rsp !== want)
						note_mismatch($sformatf("%0t: mismatch\n  expected %s\n  actual   %s",
							$realtime, show(want), show(rsp)));
				end
			end
			if (req_valid && !req_stall) expected_outputs.push_back(next_barn_outputs(req));
			outstanding <= expected_outputs.size();
		end
	end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
	import bcrc_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int REQ_BITS    = $bits(req_t);
	localparam int PHASES      = 6;
	localparam int PHASE_ITEMS = 270;
	localparam int HOLD_CYCLES = 80;

	logic                  clk;
	logic                  arst_n;
	logic                  req_valid;
	logic                  req_stall;
	req_t                  req;
	logic                  rsp_valid;
	logic                  rsp_stall;
	rsp_t                  rsp;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int mismatches;
	int outstanding;
	int send_idle_pct = 28;
	int recv_idle_pct = 77;
	int hold_asks = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int cycles = 0;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	barn_climate_and_refill_controller_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	barn_result_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.rsp         (rsp),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// result side: random stall, or a long hold-off when one is asked for
	always @(posedge clk) begin
		if (hold_seen != hold_asks) begin
			hold_seen = hold_asks;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic send_item(input req_t item);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		do @(posedge clk); while (req_stall);
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (2) @(posedge clk);
	endtask

	task automatic cfg_write(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// tick_limit, alarm_high, alarm_low, cool_above, heat_below, dark_threshold
	task automatic apply_setting(input int p);
		int v[6];
		case (p)
			0: v = '{2, 45, 5, 28, 18, 150};
			1: v = '{1, 511, 0, 511, 0, 0};
			2: v = '{63, 0, 511, 0, 511, 340};
			3: v = '{0, 120, 30, 60, 40, 200};
			default: begin
				v[0] = $urandom_range(8, 1);
				v[1] = $urandom_range(511);
				v[2] = $urandom_range(511);
				v[3] = $urandom_range(511);
				v[4] = $urandom_range(511);
				v[5] = $urandom_range(340);
			end
		endcase
		for (int i = 0; i < 6; i++) cfg_write(cfg_idx_t'(i), CFG_DATA_W'(v[i]));
		cfg_valid <= 1'b0;
	endtask

	// switch order: water open, water closed, food open, food closed
	function automatic req_t make_item(req_kind_t kind, int temp, int light, logic pin,
			logic water, logic food, logic [3:0] sw);
		req_t r;
		r.req_type            = kind;
		r.temp_sample         = TEMP_W'(temp);
		r.light_sample        = LIGHT_W'(light);
		r.night_pin           = pin;
		r.water_short         = water;
		r.food_short          = food;
		r.water_open_switch   = sw[3];
		r.water_closed_switch = sw[2];
		r.food_open_switch    = sw[1];
		r.food_closed_switch  = sw[0];
		return r;
	endfunction

	function automatic req_t random_item();
		req_t r;
		int   pick;
		r    = req_t'(REQ_BITS'($urandom));
		pick = $urandom_range(99);
		if (pick < 35)      r.req_type = REQ_TICK;
		else if (pick < 70) r.req_type = REQ_POLL;
		else if (pick < 92) r.req_type = REQ_SAMPLE;
		else                r.req_type = REQ_NIGHT;
		return r;
	endfunction

	initial begin
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		cfg_write(CFG_TICK_LIMIT, CFG_DATA_W'(1));
		cfg_valid <= 1'b0;

		// extremes, light below 3, band clearing the alarm
		send_item(make_item(REQ_SAMPLE, 0, 0, 1'b0, 1'b0, 1'b0, 4'b1111));
		send_item(make_item(REQ_SAMPLE, 1023, 1023, 1'b0, 1'b1, 1'b1, 4'b0000));
		send_item(make_item(REQ_SAMPLE, 2, 2, 1'b1, 1'b0, 1'b0, 4'b1111));
		send_item(make_item(REQ_SAMPLE, 48, 600, 1'b0, 1'b0, 1'b0, 4'b1111));
		// night: ticks frozen, lights held off on the sample that ends it
		send_item(make_item(REQ_NIGHT, 0, 0, 1'b0, 1'b0, 1'b0, 4'b1111));
		send_item(make_item(REQ_TICK, 0, 0, 1'b0, 1'b1, 1'b1, 4'b1111));
		send_item(make_item(REQ_SAMPLE, 48, 1023, 1'b1, 1'b0, 1'b0, 4'b1111));
		// full refill with a night edge deferred to its end
		send_item(make_item(REQ_TICK, 0, 0, 1'b0, 1'b1, 1'b1, 4'b1111));
		send_item(make_item(REQ_SAMPLE, 1023, 1023, 1'b1, 1'b0, 1'b0, 4'b1111));
		send_item(make_item(REQ_TICK, 0, 0, 1'b0, 1'b1, 1'b1, 4'b1111));
		send_item(make_item(REQ_NIGHT, 0, 0, 1'b0, 1'b0, 1'b0, 4'b1111));
		send_item(make_item(REQ_POLL, 0, 0, 1'b0, 1'b0, 1'b0, 4'b1111));
		send_item(make_item(REQ_POLL, 0, 0, 1'b0, 1'b0, 1'b0, 4'b0111));
		send_item(make_item(REQ_POLL, 0, 0, 1'b0, 1'b0, 1'b0, 4'b1011));
		send_item(make_item(REQ_POLL, 0, 0, 1'b0, 1'b0, 1'b0, 4'b1101));
		send_item(make_item(REQ_POLL, 0, 0, 1'b0, 1'b0, 1'b0, 4'b1110));
		send_item(make_item(REQ_POLL, 0, 0, 1'b0, 1'b0, 1'b0, 4'b0000));
		send_item(make_item(REQ_SAMPLE, 300, 0, 1'b1, 1'b0, 1'b0, 4'b1111));
		// water only, food only, neither; one phase per poll
		send_item(make_item(REQ_TICK, 0, 0, 1'b0, 1'b1, 1'b0, 4'b1111));
		send_item(make_item(REQ_POLL, 0, 0, 1'b0, 1'b0, 1'b0, 4'b0000));
		send_item(make_item(REQ_POLL, 0, 0, 1'b0, 1'b0, 1'b0, 4'b0000));
		send_item(make_item(REQ_TICK, 0, 0, 1'b0, 1'b0, 1'b1, 4'b1111));
		send_item(make_item(REQ_POLL, 0, 0, 1'b0, 1'b0, 1'b0, 4'b0000));
		send_item(make_item(REQ_POLL, 0, 0, 1'b0, 1'b0, 1'b0, 4'b0000));
		send_item(make_item(REQ_TICK, 0, 0, 1'b0, 1'b0, 1'b0, 4'b1111));

		for (int p = 0; p < PHASES; p++) begin
			wait_drained();
			apply_setting(p);
			if (p < 2) begin
				send_idle_pct = 28;
				recv_idle_pct = 77;
			end else if (p < 4) begin
				send_idle_pct = 77;
				recv_idle_pct = 28;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			// long hold-off on the result side so the input backs up
			if (p == PHASES - 2) hold_asks++;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				send_item(random_item());
				if (p == 2 && i == PHASE_ITEMS / 2) wait_drained();
			end
		end

		wait_drained();
		repeat (4) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// ----- barn_climate_and_refill_controller_unit.f -----
sv/bcrc_pkg.sv
sv/barn_climate_and_refill_controller_unit.sv
tb/sv/barn_result_checker.sv
tb/sv/testbench.sv
